// ===== rtl/dmec_pkg.sv =====
// Types, constants and helpers shared by the decimal mantissa/exponent codec.
`default_nettype none
package dmec_pkg;
	localparam logic [1:0] CFG_MANT_BITS = 2'd0;
	localparam logic [1:0] CFG_EXP_BITS  = 2'd1;
	localparam logic [1:0] CFG_COEF      = 2'd2;

	localparam logic [4:0]  MANT_BITS_RST = 5'd12;
	localparam logic [3:0]  EXP_BITS_RST  = 4'd4;
	localparam logic [31:0] COEF_RST      = 32'd65536;

	localparam logic [4:0] MANT_BITS_CAP = 5'd24;
	localparam logic [3:0] EXP_BITS_CAP  = 4'd8;
	localparam logic [7:0] POW10_COUNT   = 8'd6;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] value_in;
		logic [15:0] mantissa_in;
		logic [15:0] exponent_in;
	} item_t;

	typedef struct packed {
		logic [23:0] mantissa_out;
		logic [7:0]  exponent_out;
		logic [31:0] packed_out;
		logic [31:0] decoded_out;
		logic        status;
	} result_t;

	typedef struct packed {
		logic        func;
		logic [31:0] value;
		logic [15:0] mant;
		logic [15:0] expo;
		logic [31:0] coef;
		logic [4:0]  mb;
		logic [3:0]  eb;
		logic        invalid;
	} cmd_t;

	function automatic logic [16:0] pow10(input logic [2:0] e);
		logic [16:0] r;
		case (e)
			3'd0: r = 17'd1;
			3'd1: r = 17'd10;
			3'd2: r = 17'd100;
			3'd3: r = 17'd1000;
			3'd4: r = 17'd10000;
			3'd5: r = 17'd100000;
			default: r = 17'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/dmec_front.sv =====
// Front end: configuration registers and classification of incoming requests.
`default_nettype none
module dmec_front
	import dmec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire item_t       item,
	output cmd_t             cmd
);
	logic [4:0]  mant_bits_q;
	logic [3:0]  exp_bits_q;
	logic [31:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_bits_q <= MANT_BITS_RST;
			exp_bits_q  <= EXP_BITS_RST;
			coef_q      <= COEF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MANT_BITS: mant_bits_q <= cfg_data[4:0];
				CFG_EXP_BITS:  exp_bits_q  <= cfg_data[3:0];
				CFG_COEF:      coef_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd.func    = item.func;
		cmd.value   = item.value_in;
		cmd.mant    = item.mantissa_in;
		cmd.expo    = item.exponent_in;
		cmd.coef    = coef_q;
		cmd.mb      = (mant_bits_q > MANT_BITS_CAP) ? MANT_BITS_CAP : mant_bits_q;
		cmd.eb      = (exp_bits_q > EXP_BITS_CAP) ? EXP_BITS_CAP : exp_bits_q;
		cmd.invalid = (mant_bits_q == 5'd0) || (exp_bits_q == 4'd0) || (coef_q == 32'd0);
	end
endmodule
`default_nettype wire

// ===== rtl/dmec_queue.sv =====
// Short request queue between front end and back end.
`default_nettype none
module dmec_queue
	import dmec_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dmec_back.sv =====
// Back end: exponent search, iterative rounding divider, decode multiply, result register.
`default_nettype none
module dmec_back
	import dmec_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_empty,
	output logic      cmd_pop,
	output result_t   result,
	output logic      empty,
	input  wire logic pop
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC_MUL, ST_DEC_SUM, ST_BASE, ST_SEARCH,
		ST_DPREP, ST_DINIT, ST_DIV, ST_DONE
	} state_t;

	localparam logic [32:0] THR_SAT = 33'h1_0000_0000;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [32:0] p_q;
	logic [63:0] acc_q;
	logic [31:0] dec_q;
	logic [32:0] thr_q;
	logic [7:0]  e_q;
	logic [48:0] d_q;
	logic [49:0] rem_q;
	logic [74:0] dsh_q;
	logic [24:0] q_q;
	logic [4:0]  cnt_q;
	logic [23:0] mant_q;
	logic        out_valid_q;
	result_t     res_q;

	logic [23:0] mant_max;
	logic [7:0]  exp_max;
	logic [16:0] in_pw;
	logic [55:0] base_prod;
	logic        found;
	logic [7:0]  e_nx;
	logic [7:0]  e_fin;
	logic        search_stop;
	logic [36:0] t10;
	logic [64:0] dec_sum;
	logic [49:0] num;
	logic [49:0] den;
	logic        div_big;
	logic        div_ge;
	logic [24:0] q_nx;
	logic        slot_free;
	result_t     res_nx;

	assign mant_max  = 24'((25'd1 << cmd_q.mb) - 25'd1);
	assign exp_max   = 8'((9'd1 << cmd_q.eb) - 9'd1);
	assign in_pw     = (cmd.expo < 16'd6) ? pow10(cmd.expo[2:0]) : 17'd0;
	assign base_prod = {24'd0, cmd_q.coef} * {32'd0, mant_max};
	assign found     = ({1'b0, cmd_q.value} < thr_q);
	assign e_nx      = e_q + 8'd1;
	assign t10       = {1'b0, thr_q, 3'b000} + {3'b000, thr_q, 1'b0};
	assign dec_sum   = {1'b0, acc_q} + (p_q[32] ? {1'b0, cmd_q.coef, 32'd0} : 65'd0);
	assign num       = {1'b0, cmd_q.value, 17'd0} + {1'b0, d_q};
	assign den       = {d_q, 1'b0};
	assign div_big   = ({25'd0, num} >= {den, 25'd0});
	assign div_ge    = ({25'd0, rem_q} >= dsh_q);
	assign q_nx      = {q_q[23:0], div_ge};
	assign slot_free = !out_valid_q || pop;
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign empty     = !out_valid_q;
	assign result    = res_q;

	always_comb begin
		search_stop = 1'b1;
		e_fin       = e_q;
		if (!found) begin
			if (e_nx >= exp_max) begin
				e_fin = e_nx;
			end else if (e_nx == POW10_COUNT) begin
				e_fin = exp_max;
			end else begin
				e_fin       = e_nx;
				search_stop = 1'b0;
			end
		end
	end

	always_comb begin
		res_nx = '0;
		if (cmd_q.func == FUNC_DECODE) begin
			res_nx.decoded_out = dec_q;
		end else if (cmd_q.invalid) begin
			res_nx.status = 1'b1;
		end else begin
			res_nx.mantissa_out = mant_q;
			res_nx.exponent_out = e_q;
			res_nx.packed_out   = ({8'd0, mant_q} << cmd_q.eb) | {24'd0, e_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						p_q   <= {17'd0, cmd.mant} * {16'd0, in_pw};
						if (cmd.func == FUNC_DECODE) begin
							state_q <= ST_DEC_MUL;
						end else if (cmd.invalid) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BASE;
						end
					end
				end
				ST_DEC_MUL: begin
					acc_q   <= {32'd0, p_q[31:0]} * {32'd0, cmd_q.coef};
					state_q <= ST_DEC_SUM;
				end
				ST_DEC_SUM: begin
					dec_q   <= (|dec_sum[64:48]) ? 32'hFFFF_FFFF : dec_sum[47:16];
					state_q <= ST_DONE;
				end
				ST_BASE: begin
					thr_q   <= (|base_prod[55:48]) ? THR_SAT : {1'b0, base_prod[47:16]};
					e_q     <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					e_q <= e_fin;
					if (!search_stop) begin
						thr_q <= (|t10[36:32]) ? THR_SAT : t10[32:0];
					end else if (e_fin >= POW10_COUNT) begin
						mant_q  <= mant_max;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DPREP;
					end
				end
				ST_DPREP: begin
					d_q     <= {17'd0, cmd_q.coef} * {32'd0, pow10(e_q[2:0])};
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					if (div_big) begin
						mant_q  <= mant_max;
						state_q <= ST_DONE;
					end else begin
						rem_q   <= num;
						dsh_q   <= {1'b0, den, 24'd0};
						q_q     <= '0;
						cnt_q   <= 5'd24;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q[49:0];
					end
					q_q   <= q_nx;
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						mant_q  <= (q_nx > {1'b0, mant_max}) ? mant_max : q_nx[23:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						res_q   <= res_nx;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({26'd0, rem_q} < {dsh_q, 1'b0}))
		else $error("divider remainder out of range");

	a_search_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (e_q < exp_max))
		else $error("exponent search past limit");

	a_mant_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && cmd_q.func == FUNC_ENCODE && !cmd_q.invalid)
		|-> (mant_q <= mant_max))
		else $error("mantissa above limit");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(res_q)))
		else $error("waiting result lost");
endmodule
`default_nettype wire

// ===== rtl/decimal_mantissa_exponent_codec.sv =====
// Decimal mantissa/exponent codec: top level joining front end, queue and back end.
// Decode runs a multiply and a sum in the back end; encode runs an exponent search of up to
// 6 steps and then, unless the request is invalid or saturates, a 25-step rounding divider.
// One request is in the back end at a time; the queue holds QUEUE_DEPTH more.
// Reset empties the queue and the result register and loads the default configuration.
`default_nettype none
module decimal_mantissa_exponent_codec
	import dmec_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire item_t       item,
	output logic             full,
	input  wire logic        pop,
	output result_t          result,
	output logic             empty,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_empty;
	logic cmd_pop;

	dmec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd_in)
	);

	dmec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	dmec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);
endmodule
`default_nettype wire
